[rtl/core/pcsg_pkg.sv]
package pcsg_pkg;

  localparam int MAP_WIDTH  = 256;
  localparam int MAP_HEIGHT = 256;
  localparam int COL_W      = $clog2(MAP_WIDTH);
  localparam int ROW_W      = $clog2(MAP_HEIGHT);
  localparam int ADDR_W     = COL_W + ROW_W;

  localparam int WIN_W      = 9;
  localparam int POS_W      = 32;
  localparam int COST_W     = 8;
  localparam int CS_W       = 17;
  localparam int RAD_W      = 21;
  localparam int LVL_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int RAD2_W     = RAD_W + 1;
  localparam int RADSQ_W    = 2 * RAD2_W;
  localparam int K_W        = RAD_W + 1;
  localparam int AX_W       = 23;
  localparam int SQ_W       = 2 * AX_W;
  localparam int D2_W       = SQ_W + 1;
  localparam int SQ_IN_W    = D2_W + 1;
  localparam int ROOT_W     = SQ_IN_W / 2;
  localparam int DIV_NW     = POS_W + 2;
  localparam int DIV_DW     = RAD2_W + 1;
  localparam int OFF_W      = POS_W + 4;

  localparam logic [COST_W-1:0] COST_LETHAL  = 8'd254;
  localparam logic [COST_W-1:0] COST_UNKNOWN = 8'd255;

  typedef enum logic [1:0] {
    CMD_CLEAR, CMD_STAMP, CMD_MERGE, CMD_NONE
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE, ST_OFFMAP, ST_DISABLED, ST_OUTSIDE
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE, CFG_LETHAL, CFG_WARN, CFG_LEVEL, CFG_CELL, CFG_ORG_X, CFG_ORG_Y
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIV_X, DIV_Y, DIV_K, DIV_COST
  } div_sel_t;

  typedef enum logic [1:0] {
    RES_ZERO, RES_MASTER, RES_MERGE
  } res_kind_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_INIT_BOUNDS, OP_CLR_BOUNDS, OP_SAVE_MX, OP_SAVE_MY,
    OP_SAVE_K, OP_SQ_L, OP_SQ_W, OP_BOUNDS, OP_LOAD_XY, OP_ROW_A, OP_ROW_B,
    OP_CELL_A, OP_CELL_B, OP_CELL_C, OP_SET_LETHAL, OP_SET_ZERO, OP_NUM,
    OP_SAVE_COST
  } dp_op_t;

  typedef enum logic [4:0] {
    S_INIT_LD, S_INIT_SWEEP, S_IDLE, S_DISPATCH, S_CLR_SWEEP, S_MERGE_WAIT,
    S_DIVX_WAIT, S_DIVY_WAIT, S_DIVK_WAIT, S_SQ_L, S_SQ_W, S_BOUNDS, S_CHECK,
    S_ROW_A, S_ROW_B, S_CELL_A, S_CELL_B, S_CELL_C, S_CELL_D, S_SQRT_WAIT,
    S_NUM, S_DIVC_GO, S_DIVC_WAIT, S_WRITE, S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t    op;
    logic      div_start;
    div_sel_t  div_sel;
    logic      sqrt_start;
    logic      mem_rd;
    logic      merge_addr;
    logic      wr_zero;
    logic      wr_cost;
    logic      advance;
    logic      res_load;
    status_t   res_status;
    res_kind_t res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic enabled;
    cmd_t cmd;
    logic win_ok;
    logic merge_in;
    logic off_x;
    logic off_y;
    logic q_big;
    logic div_done;
    logic sqrt_done;
    logic box_empty;
    logic lethal;
    logic ring;
    logic row_end;
    logic last;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/core/pcsg_in_if.sv]
interface pcsg_in_if;
  import pcsg_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              cmd;
  logic [WIN_W-1:0]        win_min_x;
  logic [WIN_W-1:0]        win_min_y;
  logic [WIN_W-1:0]        win_max_x;
  logic [WIN_W-1:0]        win_max_y;
  logic signed [POS_W-1:0] person_x;
  logic signed [POS_W-1:0] person_y;
  logic [COL_W-1:0]        cell_col;
  logic [ROW_W-1:0]        cell_row;
  logic [COST_W-1:0]       master_cost;

  modport source (
    output valid, cmd, win_min_x, win_min_y, win_max_x, win_max_y,
           person_x, person_y, cell_col, cell_row, master_cost,
    input  ready
  );

  modport sink (
    input  valid, cmd, win_min_x, win_min_y, win_max_x, win_max_y,
           person_x, person_y, cell_col, cell_row, master_cost,
    output ready
  );

endinterface

[rtl/core/pcsg_out_if.sv]
interface pcsg_out_if;
  import pcsg_pkg::*;

  logic              valid;
  logic              ready;
  logic [COST_W-1:0] merged_cost;
  logic [1:0]        status;

  modport source (output valid, merged_cost, status, input ready);
  modport sink (input valid, merged_cost, status, output ready);

endinterface

[rtl/core/pcsg_div.sv]
module pcsg_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pcsg_pkg::DIV_NW-1:0] num,
  input  logic [pcsg_pkg::DIV_DW-1:0] den,
  output logic                        done,
  output logic [pcsg_pkg::DIV_NW-1:0] quo
);
  import pcsg_pkg::*;

  localparam int CNT_W = $clog2(DIV_NW);

  logic [DIV_NW-1:0] num_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW-1:0] rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   diff;
  logic              ge;

  always_comb begin
    rem_sh = {rem_r, num_r[DIV_NW-1]};
    diff   = rem_sh - {1'b0, den_r};
    ge     = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_NW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_NW-2:0], ge};
      rem_r <= ge ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

[rtl/core/pcsg_sqrt.sv]
module pcsg_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pcsg_pkg::SQ_IN_W-1:0] value,
  output logic                         done,
  output logic [pcsg_pkg::ROOT_W-1:0]  root
);
  import pcsg_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 3;

  logic [SQ_IN_W-1:0] val_r;
  logic [REM_W-1:0]   rem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [REM_W-1:0]   rem_sh;
  logic [REM_W-1:0]   trial;
  logic               ge;

  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], val_r[SQ_IN_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ROOT_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= value;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r  <= {val_r[SQ_IN_W-3:0], 2'b00};
      rem_r  <= ge ? rem_sh - trial : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[rtl/core/pcsg_datapath.sv]
module pcsg_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pcsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcsg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]                      in_cmd,
  input  logic [pcsg_pkg::WIN_W-1:0]      in_win_min_x,
  input  logic [pcsg_pkg::WIN_W-1:0]      in_win_min_y,
  input  logic [pcsg_pkg::WIN_W-1:0]      in_win_max_x,
  input  logic [pcsg_pkg::WIN_W-1:0]      in_win_max_y,
  input  logic [pcsg_pkg::POS_W-1:0]      in_person_x,
  input  logic [pcsg_pkg::POS_W-1:0]      in_person_y,
  input  logic [pcsg_pkg::COL_W-1:0]      in_cell_col,
  input  logic [pcsg_pkg::ROW_W-1:0]      in_cell_row,
  input  logic [pcsg_pkg::COST_W-1:0]     in_master_cost,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [pcsg_pkg::COST_W-1:0]     out_merged_cost,
  output logic [1:0]                      out_status,
  input  pcsg_pkg::dp_cmd_t               cmd,
  output pcsg_pkg::dp_stat_t              stat
);
  import pcsg_pkg::*;

  localparam int BW = K_W + 2;

  // configuration
  logic                en_r;
  logic [RAD_W-1:0]    lr_r;
  logic [RAD_W-1:0]    wr_r;
  logic [LVL_W-1:0]    wl_r;
  logic [CS_W-1:0]     cs_r;
  logic [POS_W-1:0]    ox_r;
  logic [POS_W-1:0]    oy_r;

  // latched item
  cmd_t                cmd_r;
  logic [WIN_W-1:0]    x0_r, y0_r, x1_r, y1_r;
  logic [POS_W-1:0]    px_r, py_r;
  logic [COL_W-1:0]    col_r;
  logic [ROW_W-1:0]    row_r;
  logic [COST_W-1:0]   mst_r;

  // stamp state
  logic [COL_W-1:0]    mx_r;
  logic [ROW_W-1:0]    my_r;
  logic [K_W-1:0]      k_r;
  logic [RADSQ_W-1:0]  l2sq_r, w2sq_r;
  logic [WIN_W-1:0]    sx_r, ex_r, sy_r, ey_r;
  logic [WIN_W-1:0]    x_r, y_r;
  logic [AX_W-1:0]     ax_r, ay_r;
  logic [SQ_W-1:0]     ax2_r, ay2_r;
  logic [D2_W-1:0]     d2_r;
  logic [COST_W-1:0]   cost_r;
  logic [DIV_NW-1:0]   cnum_r;

  // grid
  logic [COST_W-1:0]   mem [MAP_WIDTH*MAP_HEIGHT];
  logic [COST_W-1:0]   rd_data_r;
  logic [ADDR_W-1:0]   addr;

  logic                out_valid_r;
  logic [COST_W-1:0]   out_cost_r;
  logic [1:0]          out_status_r;

  logic [CS_W-1:0]       cs_eff;
  logic [LVL_W-1:0]      wl_eff;
  logic [RAD2_W-1:0]     l2, w2;
  logic [DIV_DW-1:0]     w2ml;
  logic signed [POS_W:0] dxp, dyp;
  logic [K_W-1:0]        kn;
  logic [DIV_NW-1:0]     div_num;
  logic [DIV_DW-1:0]     div_den;
  logic                  div_done;
  logic [DIV_NW-1:0]     div_q;
  logic                  sqrt_done;
  logic [ROOT_W-1:0]     sqrt_root;
  logic signed [BW-1:0]  lo_x, lo_y;
  logic [BW-1:0]         hi_x, hi_y;
  logic [WIN_W-1:0]      sx_c, ex_c, sy_c, ey_c;
  logic [DIV_DW-1:0]     w2md;
  logic                  row_end, last;
  logic [COST_W-1:0]     merged;

  function automatic logic [WIN_W-1:0] clip_win(input logic [WIN_W-1:0] v,
                                                 input logic [WIN_W-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  // magnitude of the doubled offset from a cell centre to the person
  function automatic logic [AX_W-1:0] ctr_off(input logic [WIN_W-1:0] idx,
                                               input logic [POS_W-1:0] org,
                                               input logic [POS_W-1:0] pos,
                                               input logic [CS_W-1:0]  cs);
    logic [WIN_W+CS_W:0]     prod;
    logic signed [OFF_W-1:0] dv;
    logic [OFF_W-1:0]        mag;
    prod = {idx, 1'b1} * cs;
    dv   = $signed({{(OFF_W-POS_W-1){org[POS_W-1]}}, org, 1'b0})
         + $signed({{(OFF_W-WIN_W-CS_W-1){1'b0}}, prod})
         - $signed({{(OFF_W-POS_W-1){pos[POS_W-1]}}, pos, 1'b0});
    mag  = dv[OFF_W-1] ? -dv : dv;
    return mag[AX_W-1:0];
  endfunction

  always_comb begin
    cs_eff = (cs_r == '0) ? CS_W'(1) : cs_r;
    wl_eff = (wl_r > COST_LETHAL) ? COST_LETHAL : wl_r;
    l2     = {lr_r, 1'b0};
    w2     = {wr_r, 1'b0};
    w2ml   = {1'b0, w2} - {1'b0, l2};
    w2md   = {1'b0, w2} - sqrt_root[DIV_DW-1:0];
    dxp    = $signed({px_r[POS_W-1], px_r}) - $signed({ox_r[POS_W-1], ox_r});
    dyp    = $signed({py_r[POS_W-1], py_r}) - $signed({oy_r[POS_W-1], oy_r});
    kn     = {1'b0, wr_r} + K_W'(cs_eff) - 1'b1;

    div_num = cnum_r;
    div_den = DIV_DW'(cs_eff);
    case (cmd.div_sel)
      DIV_X:    div_num = {1'b0, dxp};
      DIV_Y:    div_num = {1'b0, dyp};
      DIV_K:    div_num = DIV_NW'(kn);
      default: begin
        div_num = cnum_r;
        div_den = w2ml;
      end
    endcase

    lo_x = $signed(BW'(mx_r)) - $signed(BW'(k_r));
    lo_y = $signed(BW'(my_r)) - $signed(BW'(k_r));
    hi_x = BW'(mx_r) + BW'(k_r) + 1'b1;
    hi_y = BW'(my_r) + BW'(k_r) + 1'b1;
    sx_c = (lo_x < $signed(BW'(x0_r))) ? x0_r : lo_x[WIN_W-1:0];
    sy_c = (lo_y < $signed(BW'(y0_r))) ? y0_r : lo_y[WIN_W-1:0];
    ex_c = (hi_x < BW'(x1_r)) ? hi_x[WIN_W-1:0] : x1_r;
    ey_c = (hi_y < BW'(y1_r)) ? hi_y[WIN_W-1:0] : y1_r;

    row_end = (x_r + 1'b1) == ex_r;
    last    = row_end && ((y_r + 1'b1) == ey_r);
    addr    = cmd.merge_addr ? {row_r, col_r} : {y_r[ROW_W-1:0], x_r[COL_W-1:0]};

    merged = (mst_r == COST_UNKNOWN || mst_r < rd_data_r) ? rd_data_r : mst_r;
  end

  pcsg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  pcsg_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .value (SQ_IN_W'(d2_r)),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b1;
      lr_r <= RAD_W'(410);
      wr_r <= RAD_W'(1229);
      wl_r <= LVL_W'(180);
      cs_r <= CS_W'(51);
      ox_r <= '0;
      oy_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENABLE: en_r <= cfg_data[0];
        CFG_LETHAL: lr_r <= cfg_data[RAD_W-1:0];
        CFG_WARN:   wr_r <= cfg_data[RAD_W-1:0];
        CFG_LEVEL:  wl_r <= cfg_data[LVL_W-1:0];
        CFG_CELL:   cs_r <= cfg_data[CS_W-1:0];
        CFG_ORG_X:  ox_r <= cfg_data[POS_W-1:0];
        CFG_ORG_Y:  oy_r <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        cmd_r <= cmd_t'(in_cmd);
        x0_r  <= clip_win(in_win_min_x, WIN_W'(MAP_WIDTH));
        y0_r  <= clip_win(in_win_min_y, WIN_W'(MAP_HEIGHT));
        x1_r  <= clip_win(in_win_max_x, WIN_W'(MAP_WIDTH));
        y1_r  <= clip_win(in_win_max_y, WIN_W'(MAP_HEIGHT));
        px_r  <= in_person_x;
        py_r  <= in_person_y;
        col_r <= in_cell_col;
        row_r <= in_cell_row;
        mst_r <= in_master_cost;
      end
      OP_INIT_BOUNDS: begin
        sx_r <= '0;
        sy_r <= '0;
        ex_r <= WIN_W'(MAP_WIDTH);
        ey_r <= WIN_W'(MAP_HEIGHT);
        x_r  <= '0;
        y_r  <= '0;
      end
      OP_CLR_BOUNDS: begin
        sx_r <= x0_r;
        sy_r <= y0_r;
        ex_r <= x1_r;
        ey_r <= y1_r;
        x_r  <= x0_r;
        y_r  <= y0_r;
      end
      OP_SAVE_MX:    mx_r <= div_q[COL_W-1:0];
      OP_SAVE_MY:    my_r <= div_q[ROW_W-1:0];
      OP_SAVE_K:     k_r <= div_q[K_W-1:0];
      OP_SQ_L:       l2sq_r <= l2 * l2;
      OP_SQ_W:       w2sq_r <= w2 * w2;
      OP_BOUNDS: begin
        sx_r <= sx_c;
        sy_r <= sy_c;
        ex_r <= ex_c;
        ey_r <= ey_c;
      end
      OP_LOAD_XY: begin
        x_r <= sx_r;
        y_r <= sy_r;
      end
      OP_ROW_A:      ay_r <= ctr_off(y_r, oy_r, py_r, cs_eff);
      OP_ROW_B:      ay2_r <= ay_r * ay_r;
      OP_CELL_A:     ax_r <= ctr_off(x_r, ox_r, px_r, cs_eff);
      OP_CELL_B:     ax2_r <= ax_r * ax_r;
      OP_CELL_C:     d2_r <= {1'b0, ax2_r} + {1'b0, ay2_r};
      OP_SET_LETHAL: cost_r <= COST_LETHAL;
      OP_SET_ZERO:   cost_r <= '0;
      OP_NUM:        cnum_r <= DIV_NW'(wl_eff * w2md);
      OP_SAVE_COST:  cost_r <= div_q[COST_W-1:0];
      default: ;
    endcase
    if (cmd.advance) begin
      if (row_end) begin
        x_r <= sx_r;
        y_r <= y_r + 1'b1;
      end else begin
        x_r <= x_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) rd_data_r <= mem[addr];
    if (cmd.wr_zero) begin
      mem[addr] <= '0;
    end else if (cmd.wr_cost && cost_r > rd_data_r) begin
      mem[addr] <= cost_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status_r <= cmd.res_status;
      case (cmd.res_kind)
        RES_MASTER: out_cost_r <= mst_r;
        RES_MERGE:  out_cost_r <= merged;
        default:    out_cost_r <= '0;
      endcase
    end
  end

  always_comb begin
    stat.enabled   = en_r;
    stat.cmd       = cmd_r;
    stat.win_ok    = (x0_r < x1_r) && (y0_r < y1_r);
    stat.merge_in  = ({1'b0, col_r} >= x0_r) && ({1'b0, col_r} < x1_r)
                  && ({1'b0, row_r} >= y0_r) && ({1'b0, row_r} < y1_r);
    stat.off_x     = dxp[POS_W];
    stat.off_y     = dyp[POS_W];
    stat.q_big     = |div_q[DIV_NW-1:COL_W];
    stat.div_done  = div_done;
    stat.sqrt_done = sqrt_done;
    stat.box_empty = (sx_r >= ex_r) || (sy_r >= ey_r);
    stat.lethal    = d2_r <= D2_W'(l2sq_r);
    stat.ring      = d2_r <= D2_W'(w2sq_r);
    stat.row_end   = row_end;
    stat.last      = last;
    stat.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_merged_cost = out_cost_r;
  assign out_status      = out_status_r;

endmodule

[rtl/core/pcsg_ctrl.sv]
module pcsg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pcsg_pkg::dp_stat_t stat,
  output pcsg_pkg::dp_cmd_t  cmd
);
  import pcsg_pkg::*;

  ctrl_state_t state_r, state_nxt;
  status_t     res_status_r, res_status_nxt;
  res_kind_t   res_kind_r, res_kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT_LD;
      res_status_r <= ST_DONE;
      res_kind_r   <= RES_ZERO;
    end else begin
      state_r      <= state_nxt;
      res_status_r <= res_status_nxt;
      res_kind_r   <= res_kind_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_kind_nxt   = res_kind_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.op         = OP_NONE;
    cmd.div_sel    = DIV_X;
    cmd.res_status = res_status_r;
    cmd.res_kind   = res_kind_r;

    unique case (state_r)
      S_INIT_LD: begin
        cmd.op    = OP_INIT_BOUNDS;
        state_nxt = S_INIT_SWEEP;
      end
      S_INIT_SWEEP: begin
        cmd.wr_zero = 1'b1;
        cmd.advance = 1'b1;
        if (stat.last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_status_nxt = ST_DONE;
        res_kind_nxt   = RES_ZERO;
        if (!stat.enabled) begin
          res_status_nxt = ST_DISABLED;
          state_nxt      = S_FINISH;
        end else begin
          unique case (stat.cmd)
            CMD_CLEAR: begin
              if (stat.win_ok) begin
                cmd.op    = OP_CLR_BOUNDS;
                state_nxt = S_CLR_SWEEP;
              end else begin
                state_nxt = S_FINISH;
              end
            end
            CMD_STAMP: begin
              if (stat.off_x) begin
                res_status_nxt = ST_OFFMAP;
                state_nxt      = S_FINISH;
              end else begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_X;
                state_nxt     = S_DIVX_WAIT;
              end
            end
            CMD_MERGE: begin
              if (stat.merge_in) begin
                cmd.merge_addr = 1'b1;
                cmd.mem_rd     = 1'b1;
                state_nxt      = S_MERGE_WAIT;
              end else begin
                res_status_nxt = ST_OUTSIDE;
                res_kind_nxt   = RES_MASTER;
                state_nxt      = S_FINISH;
              end
            end
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      S_CLR_SWEEP: begin
        cmd.wr_zero = 1'b1;
        cmd.advance = 1'b1;
        if (stat.last) state_nxt = S_FINISH;
      end
      S_MERGE_WAIT: begin
        res_kind_nxt = RES_MERGE;
        state_nxt    = S_FINISH;
      end
      S_DIVX_WAIT: begin
        if (stat.div_done) begin
          if (stat.q_big || stat.off_y) begin
            res_status_nxt = ST_OFFMAP;
            state_nxt      = S_FINISH;
          end else begin
            cmd.op        = OP_SAVE_MX;
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_Y;
            state_nxt     = S_DIVY_WAIT;
          end
        end
      end
      S_DIVY_WAIT: begin
        cmd.div_sel = DIV_Y;
        if (stat.div_done) begin
          if (stat.q_big) begin
            res_status_nxt = ST_OFFMAP;
            state_nxt      = S_FINISH;
          end else begin
            cmd.op        = OP_SAVE_MY;
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_K;
            state_nxt     = S_DIVK_WAIT;
          end
        end
      end
      S_DIVK_WAIT: begin
        if (stat.div_done) begin
          cmd.op    = OP_SAVE_K;
          state_nxt = S_SQ_L;
        end
      end
      S_SQ_L: begin
        cmd.op    = OP_SQ_L;
        state_nxt = S_SQ_W;
      end
      S_SQ_W: begin
        cmd.op    = OP_SQ_W;
        state_nxt = S_BOUNDS;
      end
      S_BOUNDS: begin
        cmd.op    = OP_BOUNDS;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.op    = OP_LOAD_XY;
        state_nxt = stat.box_empty ? S_FINISH : S_ROW_A;
      end
      S_ROW_A: begin
        cmd.op    = OP_ROW_A;
        state_nxt = S_ROW_B;
      end
      S_ROW_B: begin
        cmd.op    = OP_ROW_B;
        state_nxt = S_CELL_A;
      end
      S_CELL_A: begin
        cmd.op     = OP_CELL_A;
        cmd.mem_rd = 1'b1;
        state_nxt  = S_CELL_B;
      end
      S_CELL_B: begin
        cmd.op    = OP_CELL_B;
        state_nxt = S_CELL_C;
      end
      S_CELL_C: begin
        cmd.op    = OP_CELL_C;
        state_nxt = S_CELL_D;
      end
      S_CELL_D: begin
        if (stat.lethal) begin
          cmd.op    = OP_SET_LETHAL;
          state_nxt = S_WRITE;
        end else if (stat.ring) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = S_SQRT_WAIT;
        end else begin
          cmd.op    = OP_SET_ZERO;
          state_nxt = S_WRITE;
        end
      end
      S_SQRT_WAIT: begin
        if (stat.sqrt_done) state_nxt = S_NUM;
      end
      S_NUM: begin
        cmd.op    = OP_NUM;
        state_nxt = S_DIVC_GO;
      end
      S_DIVC_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_COST;
        state_nxt     = S_DIVC_WAIT;
      end
      S_DIVC_WAIT: begin
        cmd.div_sel = DIV_COST;
        if (stat.div_done) begin
          cmd.op    = OP_SAVE_COST;
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr_cost = 1'b1;
        cmd.advance = 1'b1;
        if (stat.last) state_nxt = S_FINISH;
        else if (stat.row_end) state_nxt = S_ROW_A;
        else state_nxt = S_CELL_A;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[rtl/core/person_cost_stamp_grid.sv]
// Cost grid of 256 x 256 bytes that marks the space around people.
// Input channel in_ch carries one command per item: clear a window, stamp a
// person, or merge one cell with a master cost. Every item gives exactly one
// result item on out_ch (merged cost and a status code).
// Configuration is to be written via cfg_we / cfg_index / cfg_data while idle.
// A merge reads the addressed cell once; a clear zeroes each window cell in
// turn; a stamp first sets up with three passes of the one-bit-per-cycle
// divider, then works its box row by row: cells outside the warning ring or
// inside the lethal radius get their cost directly, and each ring cell waits
// for a 24-step square root and a 34-step divide (the divider is shared
// between setup and ring cells).
// One item is worked at a time; the next item is taken as soon as the result
// sits in the output register, so while the receiver stalls one result waits
// there and at most one more item is worked. A result waits in the output
// register until out_ch.ready.
// After reset a clearing pass zeroes all 65536 cells of the grid, one cell
// per cycle, during which in_ch.ready stays low; configuration writes are
// taken at any time and registers return to their defaults at reset.
module person_cost_stamp_grid (
  input  logic                            clk,
  input  logic                            rst_n,
  pcsg_in_if.sink                         in_ch,
  pcsg_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [pcsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcsg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pcsg_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pcsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pcsg_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_cmd          (in_ch.cmd),
    .in_win_min_x    (in_ch.win_min_x),
    .in_win_min_y    (in_ch.win_min_y),
    .in_win_max_x    (in_ch.win_max_x),
    .in_win_max_y    (in_ch.win_max_y),
    .in_person_x     (in_ch.person_x),
    .in_person_y     (in_ch.person_y),
    .in_cell_col     (in_ch.cell_col),
    .in_cell_row     (in_ch.cell_row),
    .in_master_cost  (in_ch.master_cost),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_merged_cost (out_ch.merged_cost),
    .out_status      (out_ch.status),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
module tb;
  import pcsg_pkg::*;

  typedef struct {
    cmd_t                    cmd;
    logic [WIN_W-1:0]        x0, y0, x1, y1;
    logic signed [POS_W-1:0] px, py;
    logic [COL_W-1:0]        col;
    logic [ROW_W-1:0]        row;
    logic [COST_W-1:0]       master;
  } order_t;

  typedef struct {
    logic [COST_W-1:0] cost;
    status_t           st;
  } outcome_t;

  localparam int LIMIT = 6_000_000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pcsg_in_if in_ch();
  pcsg_out_if out_ch();

  person_cost_stamp_grid dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // grid model and its registers
  logic [7:0] layer_cost [0:65535];
  bit     en;
  longint leth_rad, warn_rad, warn_lvl, csz, org_x, org_y;

  outcome_t pending_costs[$];
  int fails = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int last_col = 128, last_row = 128;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) out_ch.ready <= ($urandom_range(0, 99) >= recv_stall);

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    fails++;
  endtask

  always @(posedge clk) begin
    outcome_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_costs.size() == 0) begin
        report("unexpected item", out_ch.status, -1);
      end else begin
        w = pending_costs.pop_front();
        if (out_ch.merged_cost !== w.cost) report("merged_cost", out_ch.merged_cost, w.cost);
        if (out_ch.status !== w.st) report("status", out_ch.status, w.st);
      end
    end
  end

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic stamp_cells(longint px, longint py, longint mx, longint my,
                             longint x0, longint y0, longint x1, longint y1);
    longint cs, k, sx, sy, ex, ey, l2, w2, wl, dx, dy, ax, ay, d2, c;
    cs = csz ? csz : 1;
    k = (warn_rad + cs - 1) / cs;
    sx = (mx - k > x0) ? mx - k : x0;
    sy = (my - k > y0) ? my - k : y0;
    ex = (mx + k + 1 < x1) ? mx + k + 1 : x1;
    ey = (my + k + 1 < y1) ? my + k + 1 : y1;
    l2 = 2 * leth_rad;
    w2 = 2 * warn_rad;
    wl = (warn_lvl > 254) ? 254 : warn_lvl;
    for (longint y = sy; y < ey; y++) begin
      dy = 2 * org_y + (2 * y + 1) * cs - 2 * py;
      ay = dy < 0 ? -dy : dy;
      for (longint x = sx; x < ex; x++) begin
        dx = 2 * org_x + (2 * x + 1) * cs - 2 * px;
        ax = dx < 0 ? -dx : dx;
        d2 = ax * ax + ay * ay;
        c = 0;
        if (d2 <= l2 * l2) c = 254;
        else if (d2 <= w2 * w2) c = wl * (w2 - longint'(int_root(d2))) / (w2 - l2);
        if (c > layer_cost[y * 256 + x]) layer_cost[y * 256 + x] = c[7:0];
      end
    end
  endtask

  task automatic predict_cost(order_t o, output outcome_t r);
    longint x0, y0, x1, y1, cs, px, py, ddx, ddy, l, m;
    x0 = o.x0 > 256 ? 256 : o.x0;
    y0 = o.y0 > 256 ? 256 : o.y0;
    x1 = o.x1 > 256 ? 256 : o.x1;
    y1 = o.y1 > 256 ? 256 : o.y1;
    r.cost = 0;
    r.st = ST_DONE;
    if (!en) begin
      r.st = ST_DISABLED;
    end else begin
      case (o.cmd)
        CMD_CLEAR: begin
          for (longint y = y0; y < y1; y++)
            for (longint x = x0; x < x1; x++) layer_cost[y * 256 + x] = 0;
        end
        CMD_STAMP: begin
          cs = csz ? csz : 1;
          px = o.px;
          py = o.py;
          ddx = px - org_x;
          ddy = py - org_y;
          if (ddx < 0 || ddy < 0 || ddx / cs >= 256 || ddy / cs >= 256) r.st = ST_OFFMAP;
          else stamp_cells(px, py, ddx / cs, ddy / cs, x0, y0, x1, y1);
        end
        CMD_MERGE: begin
          m = o.master;
          if (o.col < x0 || o.col >= x1 || o.row < y0 || o.row >= y1) begin
            r.cost = o.master;
            r.st = ST_OUTSIDE;
          end else begin
            l = layer_cost[o.row * 256 + o.col];
            r.cost = (m == 255 || m < l) ? l[7:0] : m[7:0];
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic send_item(order_t o);
    outcome_t r;
    if ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= o.cmd;
    in_ch.win_min_x <= o.x0;
    in_ch.win_min_y <= o.y0;
    in_ch.win_max_x <= o.x1;
    in_ch.win_max_y <= o.y1;
    in_ch.person_x <= o.px;
    in_ch.person_y <= o.py;
    in_ch.cell_col <= o.col;
    in_ch.cell_row <= o.row;
    in_ch.master_cost <= o.master;
    do @(posedge clk); while (!in_ch.ready);
    predict_cost(o, r);
    pending_costs.push_back(r);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_costs.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_ENABLE: en = val[0];
      CFG_LETHAL: leth_rad = val[20:0];
      CFG_WARN:   warn_rad = val[20:0];
      CFG_LEVEL:  warn_lvl = val[7:0];
      CFG_CELL:   csz = val[16:0];
      CFG_ORG_X:  org_x = longint'($signed(val));
      CFG_ORG_Y:  org_y = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(longint cs, longint warn, longint leth, longint lvl,
                            longint ox, longint oy);
    wait_idle();
    write_reg(CFG_CELL, 32'(cs));
    write_reg(CFG_WARN, 32'(warn));
    write_reg(CFG_LETHAL, 32'(leth));
    write_reg(CFG_LEVEL, 32'(lvl));
    write_reg(CFG_ORG_X, 32'(ox));
    write_reg(CFG_ORG_Y, 32'(oy));
    end_writes();
  endtask

  function automatic order_t make_order(cmd_t c, int x0, int y0, int x1, int y1,
                                        longint px, longint py, int col, int row,
                                        int master);
    order_t o;
    o.cmd = c;
    o.x0 = WIN_W'(x0); o.y0 = WIN_W'(y0); o.x1 = WIN_W'(x1); o.y1 = WIN_W'(y1);
    o.px = POS_W'(px); o.py = POS_W'(py);
    o.col = COL_W'(col); o.row = ROW_W'(row); o.master = COST_W'(master);
    return o;
  endfunction

  function automatic void rand_window(output int lo, output int hi);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      lo = 0; hi = 256;
    end else if (pick < 8) begin
      lo = $urandom_range(0, 256); hi = lo + $urandom_range(0, 8);
    end else if (pick < 9) begin
      lo = $urandom_range(248, 511); hi = 511;
    end else begin
      lo = $urandom_range(0, 511); hi = $urandom_range(0, 511);
      if (hi > lo + 8) hi = lo + 8;
    end
  endfunction

  function automatic order_t random_order();
    order_t o;
    int pick, x0, x1, y0, y1, col, row;
    longint cs;
    cs = csz ? csz : 1;
    pick = $urandom_range(0, 99);
    rand_window(x0, x1);
    rand_window(y0, y1);
    o = make_order(CMD_NONE, x0, y0, x1, y1, $urandom, $urandom,
                   $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 3) == 0 ? 255 : $urandom_range(0, 255));
    if (pick < 35) begin
      o.cmd = CMD_STAMP;
      if ($urandom_range(0, 9) != 0) begin
        last_col = $urandom_range(0, 255);
        last_row = $urandom_range(0, 255);
        o.px = POS_W'(org_x + last_col * cs + $urandom_range(0, cs - 1));
        o.py = POS_W'(org_y + last_row * cs + $urandom_range(0, cs - 1));
      end
    end else if (pick < 60) begin
      o.cmd = CMD_MERGE;
      col = last_col + $urandom_range(0, 6) - 3;
      row = last_row + $urandom_range(0, 6) - 3;
      o.col = COL_W'(col < 0 ? 0 : (col > 255 ? 255 : col));
      o.row = ROW_W'(row < 0 ? 0 : (row > 255 ? 255 : row));
      if ($urandom_range(0, 2) != 0) begin
        o.x0 = '0; o.y0 = '0; o.x1 = WIN_W'(256); o.y1 = WIN_W'(256);
      end
    end else if (pick < 75) begin
      o.cmd = CMD_CLEAR;
      if (o.x1 - o.x0 > 8 && o.y1 - o.y0 > 8) o.y1 = WIN_W'(o.y0 + 4);
    end else if (pick < 92) begin
      o.cmd = CMD_MERGE;
    end
    return o;
  endfunction

  task automatic test_basics();
    send_item(make_order(CMD_MERGE, 0, 0, 256, 256, 0, 0, 0, 0, 0));
    send_item(make_order(CMD_CLEAR, 0, 0, 256, 256, 0, 0, 0, 0, 0));
    send_item(make_order(CMD_STAMP, 96, 96, 105, 105, 51 * 100 + 25, 51 * 100 + 25, 0, 0, 0));
    send_item(make_order(CMD_MERGE, 0, 0, 256, 256, 0, 0, 100, 100, 255));
    send_item(make_order(CMD_MERGE, 0, 0, 256, 256, 0, 0, 103, 100, 253));
    send_item(make_order(CMD_MERGE, 0, 0, 256, 256, 0, 0, 104, 98, 7));
    send_item(make_order(CMD_MERGE, 101, 0, 256, 256, 0, 0, 100, 100, 0));
    send_item(make_order(CMD_MERGE, 0, 0, 511, 511, 0, 0, 255, 255, 255));
    send_item(make_order(CMD_STAMP, 0, 0, 256, 256, -1, 100, 0, 0, 0));
    send_item(make_order(CMD_STAMP, 0, 0, 256, 256, 100, 256 * 51, 0, 0, 0));
    send_item(make_order(CMD_STAMP, 0, 0, 256, 256, 32'h7fffffff, 32'h80000000, 0, 0, 0));
    send_item(make_order(CMD_NONE, 511, 511, 511, 511, -1, -1, 255, 255, 255));
    send_item(make_order(CMD_CLEAR, 102, 99, 100, 101, 0, 0, 0, 0, 0));
    send_item(make_order(CMD_CLEAR, 100, 100, 102, 511, 0, 0, 0, 0, 0));
    send_item(make_order(CMD_MERGE, 0, 0, 256, 256, 0, 0, 100, 100, 0));
  endtask

  task automatic test_disable();
    wait_idle();
    write_reg(CFG_ENABLE, 0);
    end_writes();
    send_item(make_order(CMD_CLEAR, 0, 0, 256, 256, 0, 0, 0, 0, 0));
    send_item(make_order(CMD_STAMP, 0, 0, 256, 256, 200, 200, 0, 0, 0));
    send_item(make_order(CMD_MERGE, 0, 0, 256, 256, 0, 0, 103, 100, 9));
    wait_idle();
    write_reg(CFG_ENABLE, 1);
    end_writes();
    send_item(make_order(CMD_MERGE, 0, 0, 256, 256, 0, 0, 103, 100, 9));
  endtask

  task automatic test_extremes();
    set_config(65536, 1048576, 1048576, 255, 0, 0);
    send_item(make_order(CMD_STAMP, 0, 0, 256, 256, 128 * 65536, 128 * 65536 + 1, 0, 0, 0));
    send_item(make_order(CMD_MERGE, 0, 0, 256, 256, 0, 0, 128, 128, 100));
    send_item(make_order(CMD_MERGE, 0, 0, 256, 256, 0, 0, 144, 128, 255));
    set_config(0, 0, 0, 0, 32'h80000000, 32'h7fffffff);
    send_item(make_order(CMD_STAMP, 0, 0, 256, 256, 32'h80000005, 32'h7fffffff, 0, 0, 0));
    send_item(make_order(CMD_MERGE, 0, 0, 256, 256, 0, 0, 5, 0, 255));
    send_item(make_order(CMD_CLEAR, 0, 0, 256, 256, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random(int idle_pct, int stall_pct, int count);
    send_idle = idle_pct;
    recv_stall = stall_pct;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_idle();
      send_item(random_order());
    end
  endtask

  initial begin
    en = 1; leth_rad = 410; warn_rad = 1229; warn_lvl = 180; csz = 51; org_x = 0; org_y = 0;
    for (int i = 0; i < 65536; i++) layer_cost[i] = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_ch.valid = 0; in_ch.cmd = 0;
    in_ch.win_min_x = 0; in_ch.win_min_y = 0; in_ch.win_max_x = 0; in_ch.win_max_y = 0;
    in_ch.person_x = 0; in_ch.person_y = 0;
    in_ch.cell_col = 0; in_ch.cell_row = 0; in_ch.master_cost = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_basics();
    test_disable();
    test_extremes();
    set_config(64, 150, 60, 200, 1000, -2000);
    test_random(24, 51, 80);
    set_config(0, 3, 1, 255, -5, 17);
    test_random(51, 24, 80);
    set_config(65536, 131072, 0, 254, 32'h80000000, -8000000);
    test_random(0, 0, 80);
    wait_idle();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/pcsg_pkg.sv
rtl/core/pcsg_in_if.sv
rtl/core/pcsg_out_if.sv
rtl/core/pcsg_div.sv
rtl/core/pcsg_sqrt.sv
rtl/core/pcsg_datapath.sv
rtl/core/pcsg_ctrl.sv
rtl/core/person_cost_stamp_grid.sv
tb/sv/tb.sv
